// ----- hdl/lsta_pkg.sv -----
// Package: types, codes and sizes shared by the link state table aging block.
`timescale 1ns / 1ps
package lsta_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_LOOKUP = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_REACH  = 3'd4;

  localparam logic [2:0] EV_INSERT_ACK = 3'd0;
  localparam logic [2:0] EV_REACH_ACK  = 3'd3;
  localparam logic [2:0] EV_REFRESH    = 3'd4;
  localparam logic [2:0] EV_REGEN      = 3'd5;
  localparam logic [2:0] EV_EXPIRED    = 3'd6;
  localparam logic [2:0] EV_TICK_DONE  = 3'd7;

  localparam logic [1:0] CFG_OWN_ID  = 2'd0;
  localparam logic [1:0] CFG_MAX_AGE = 2'd1;
  localparam logic [1:0] CFG_REFRESH = 2'd2;
  localparam logic [1:0] CFG_MAX_SEQ = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic               record_type;
    logic [31:0]        router_id;
    logic [15:0]        record_age;
    logic signed [31:0] sequence_req;
    logic               reachable;
    logic               neighbors_busy;
  } lsta_in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic               found;
    logic               table_full;
    logic               out_type;
    logic [31:0]        out_router;
    logic [15:0]        out_age;
    logic signed [31:0] out_sequence;
    logic               last;
  } lsta_out_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             finish;
    logic             tick0;
    logic             tick1;
    logic             done;
    logic [IDX_W-1:0] idx;
  } lsta_cmd_t;

  function automatic logic kind_known(input logic [2:0] k);
    return (k == KIND_INSERT) || (k == KIND_DELETE) || (k == KIND_LOOKUP) ||
           (k == KIND_TICK) || (k == KIND_REACH);
  endfunction

endpackage

// ----- hdl/lsta_ctrl.sv -----
// Controller: sequences slot scans, operation finish and the aging walk.
`timescale 1ns / 1ps
module lsta_ctrl import lsta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] kind_i,
  output logic       busy,
  output lsta_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_T0   = 3'd3;
  localparam logic [2:0] S_T1   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_idx;

  assign last_idx = (idx_q == IDX_W'(TABLE_SLOTS - 1));
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (start && kind_known(kind_i)) begin
          state_d = (kind_i == KIND_TICK) ? S_T0 : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_idx) state_d = S_FIN;
        else idx_d = idx_q + 1'b1;
      end
      S_T0: state_d = S_T1;
      S_T1: begin
        if (last_idx) state_d = S_DONE;
        else begin
          state_d = S_T0;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_FIN, S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && start && kind_known(kind_i);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.finish = (state_q == S_FIN);
    cmd_o.tick0  = (state_q == S_T0);
    cmd_o.tick1  = (state_q == S_T1);
    cmd_o.done   = (state_q == S_DONE);
    cmd_o.idx    = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- hdl/lsta_dp.sv -----
// Datapath: slot storage, config registers, scan accumulators, result register.
`timescale 1ns / 1ps
module lsta_dp import lsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lsta_cmd_t   cmd_i,
  input  lsta_in_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        res_valid_o,
  output lsta_out_t   res_o
);

  logic [TABLE_SLOTS-1:0] valid_q, reach_q;
  logic                   type_q   [TABLE_SLOTS];
  logic [31:0]            router_q [TABLE_SLOTS];
  logic [15:0]            age_q    [TABLE_SLOTS];
  logic [31:0]            seq_q    [TABLE_SLOTS];

  logic [31:0] own_q, maxseq_q;
  logic [15:0] maxage_q, refresh_q;

  lsta_in_t         it_q;
  logic             hit_q, free_q, mark_q, any_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [15:0]      hit_age_q;
  logic [31:0]      hit_seq_q;
  logic [15:0]      old_q;
  logic [31:0]      oldseq_q;
  logic             tv_q, self_q, unreach_q;

  logic        res_valid_q;
  lsta_out_t   res_q, res_d;

  // current slot view
  logic        c_valid, c_type, c_reach, c_rmatch, c_kmatch, c_self;
  logic [31:0] c_router, c_seq, c_seq_inc;
  logic [15:0] c_age, c_age_inc, c_newage;
  logic        c_inc, c_own_old;

  assign c_valid   = valid_q[cmd_i.idx];
  assign c_type    = type_q[cmd_i.idx];
  assign c_reach   = reach_q[cmd_i.idx];
  assign c_router  = router_q[cmd_i.idx];
  assign c_age     = age_q[cmd_i.idx];
  assign c_seq     = seq_q[cmd_i.idx];
  assign c_rmatch  = c_valid && (c_router == it_q.router_id);
  assign c_kmatch  = c_rmatch && (c_type == it_q.record_type);
  assign c_self    = (c_router == own_q);
  assign c_seq_inc = c_seq + 32'd1;
  assign c_age_inc = c_age + 16'd1;
  // old < limit - 1, done as old + 1 < limit in 17 bits
  assign c_inc     = c_self ? (({1'b0, c_age} + 17'd1) < {1'b0, refresh_q})
                            : (({1'b0, c_age} + 17'd1) < {1'b0, maxage_q});
  assign c_newage  = c_inc ? c_age_inc : c_age;
  assign c_own_old = c_self && (c_age > refresh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= '0;
      maxage_q  <= 16'd3600;
      refresh_q <= 16'd1800;
      maxseq_q  <= 32'h7fff_ffff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ID:  own_q     <= cfg_data_i;
        CFG_MAX_AGE: maxage_q  <= cfg_data_i[15:0];
        CFG_REFRESH: refresh_q <= cfg_data_i[15:0];
        CFG_MAX_SEQ: maxseq_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid and reach marks: reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      reach_q <= '0;
    end else begin
      if (cmd_i.scan && it_q.kind == KIND_REACH && c_rmatch) begin
        reach_q[cmd_i.idx] <= it_q.reachable;
      end
      if (cmd_i.finish) begin
        if (it_q.kind == KIND_INSERT && !hit_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
          reach_q[free_idx_q] <= mark_q;
        end
        if (it_q.kind == KIND_DELETE && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
          reach_q[hit_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.tick1 && tv_q && old_q >= maxage_q && !it_q.neighbors_busy &&
          (!self_q || unreach_q)) begin
        valid_q[cmd_i.idx] <= 1'b0;
        reach_q[cmd_i.idx] <= 1'b0;
      end
    end
  end

  // record payload: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && it_q.kind == KIND_INSERT) begin
      if (hit_q) begin
        age_q[hit_idx_q] <= it_q.record_age;
        seq_q[hit_idx_q] <= it_q.sequence_req;
      end else if (free_q) begin
        type_q[free_idx_q]   <= it_q.record_type;
        router_q[free_idx_q] <= it_q.router_id;
        age_q[free_idx_q]    <= it_q.record_age;
        seq_q[free_idx_q]    <= it_q.sequence_req;
      end
    end
    if (cmd_i.tick0 && c_valid) begin
      if (c_own_old && c_reach && c_seq != maxseq_q) begin
        age_q[cmd_i.idx] <= '0;
        seq_q[cmd_i.idx] <= c_seq_inc;
      end else begin
        age_q[cmd_i.idx] <= c_newage;
      end
    end
    if (cmd_i.tick1 && tv_q && old_q >= maxage_q && !it_q.neighbors_busy &&
        self_q && !unreach_q) begin
      age_q[cmd_i.idx] <= '0;
      seq_q[cmd_i.idx] <= oldseq_q + 32'd1;
    end
  end

  // item latch, scan accumulators, per-slot tick snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q   <= item_i;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      mark_q <= 1'b0;
      any_q  <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (c_kmatch && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmd_i.idx;
        hit_age_q <= c_age;
        hit_seq_q <= c_seq;
      end
      if (!c_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmd_i.idx;
      end
      if (c_rmatch) begin
        mark_q <= c_reach;
        any_q  <= 1'b1;
      end
    end
    if (cmd_i.tick0) begin
      tv_q      <= c_valid;
      old_q     <= c_age;
      oldseq_q  <= c_seq;
      self_q    <= c_self;
      unreach_q <= !c_reach;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else begin
      res_valid_q <= cmd_i.finish || cmd_i.done ||
                     (cmd_i.tick0 && c_valid &&
                      (c_own_old ||
                       (!c_self && ({1'b0, c_newage} + 17'd1) == {1'b0, maxage_q}))) ||
                     (cmd_i.tick1 && tv_q && old_q >= maxage_q && !it_q.neighbors_busy);
    end
  end

  always_comb begin
    res_d.table_full   = 1'b0;
    res_d.last         = 1'b0;
    res_d.found        = 1'b1;
    res_d.out_type     = c_type;
    res_d.out_router   = c_router;
    res_d.out_age      = maxage_q;
    res_d.out_sequence = c_seq;
    res_d.event_res    = EV_REFRESH;
    if (cmd_i.finish) begin
      res_d.last       = 1'b1;
      res_d.out_type   = it_q.record_type;
      res_d.out_router = it_q.router_id;
      case (it_q.kind)
        KIND_INSERT: begin
          res_d.event_res    = EV_INSERT_ACK;
          res_d.found        = hit_q;
          res_d.table_full   = !hit_q && !free_q;
          res_d.out_age      = it_q.record_age;
          res_d.out_sequence = it_q.sequence_req;
        end
        KIND_DELETE, KIND_LOOKUP: begin
          res_d.event_res    = it_q.kind;
          res_d.found        = hit_q;
          res_d.out_age      = hit_q ? hit_age_q : 16'd0;
          res_d.out_sequence = hit_q ? hit_seq_q : 32'd0;
        end
        default: begin
          res_d.event_res    = EV_REACH_ACK;
          res_d.found        = any_q;
          res_d.out_age      = '0;
          res_d.out_sequence = '0;
        end
      endcase
    end else if (cmd_i.tick0) begin
      if (c_own_old && c_reach && c_seq != maxseq_q) begin
        res_d.event_res    = EV_REGEN;
        res_d.out_age      = '0;
        res_d.out_sequence = c_seq_inc;
      end
    end else if (cmd_i.tick1) begin
      if (!self_q || unreach_q) begin
        res_d.event_res = EV_EXPIRED;
        res_d.out_age   = c_age;
      end else begin
        res_d.event_res    = EV_REGEN;
        res_d.out_age      = '0;
        res_d.out_sequence = oldseq_q + 32'd1;
      end
    end else if (cmd_i.done) begin
      res_d           = '0;
      res_d.event_res = EV_TICK_DONE;
      res_d.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/link_state_table_aging.sv -----
// Top level: link state record table with aging, controller plus datapath.
`timescale 1ns / 1ps
// Insert, delete, lookup, set reachability: a scan state for every slot, then a finish state;
//   result strobed in the cycle after the finish state; busy through the scan and finish.
// Age tick: per slot an age/refresh state, then an expiry state, then a done state;
//   busy for the whole walk; results stream out at most one per cycle behind the walk, done last.
// The single slot read port walked by the controller sets this order; receiver never stalls.
// Reset (async, active low) clears valid and reach marks, loads config defaults.
module link_state_table_aging import lsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lsta_in_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output lsta_out_t   result_o
);

  lsta_cmd_t cmd;

  // sequencer: scan walk, finish, two-phase aging walk
  lsta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // table storage and result transaction register
  lsta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  // a tick transaction always leaves the block busy for its walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_TICK) |=> busy)
    else $error("tick accepted but block not busy");

  // results only come out of work that was under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // tick done closes the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.event_res == EV_TICK_DONE) |-> result_o.last)
    else $error("tick done without last");

  // a final result means the controller went idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy)
    else $error("last result while still busy");

endmodule

// ----- bench/lsta_checker.sv -----
// Checker: watches the item and result channels, predicts table behavior, compares.
`timescale 1ns / 1ps
module lsta_checker import lsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  lsta_in_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        result_valid_o,
  input  lsta_out_t   result_o,
  output int          fail_count,
  output int          pending
);

  logic [31:0] own_id;
  logic [15:0] age_limit, refresh_limit;
  logic [31:0] seq_limit;

  logic        tv [TABLE_SLOTS];
  logic        tt [TABLE_SLOTS];
  logic [31:0] tr [TABLE_SLOTS];
  logic [15:0] ta [TABLE_SLOTS];
  logic [31:0] ts [TABLE_SLOTS];
  logic        tm [TABLE_SLOTS];

  lsta_out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic lsta_out_t mk(logic [2:0] ev, logic f, logic full, logic ty,
                                   logic [31:0] r, logic [15:0] a, logic [31:0] s,
                                   logic l);
    lsta_out_t o;
    o.event_res = ev; o.found = f; o.table_full = full; o.out_type = ty;
    o.out_router = r; o.out_age = a; o.out_sequence = s; o.last = l;
    return o;
  endfunction

  function automatic void queue_result(input lsta_out_t o);
    expected_results.insert(expected_results.size(), o);
  endfunction

  task automatic age_walk(input logic nb);
    int old, mx, rf;
    logic [31:0] oseq;
    logic self, unr;
    mx = int'(age_limit); rf = int'(refresh_limit);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!tv[i]) continue;
      old = int'(ta[i]); oseq = ts[i];
      self = (tr[i] == own_id); unr = !tm[i];
      if ((self && old < rf - 1) || (!self && old < mx - 1)) ta[i] = 16'(old + 1);
      if (self && old > rf) begin
        if (unr || oseq == seq_limit)
          queue_result(mk(EV_REFRESH, 1, 0, tt[i], tr[i], age_limit, ts[i], 0));
        else begin
          ta[i] = 0; ts[i] = oseq + 32'd1;
          queue_result(mk(EV_REGEN, 1, 0, tt[i], tr[i], 0, ts[i], 0));
        end
      end
      if (!self && int'(ta[i]) == mx - 1)
        queue_result(mk(EV_REFRESH, 1, 0, tt[i], tr[i], age_limit, ts[i], 0));
      if (old >= mx && !nb) begin
        if (!self || unr) begin
          queue_result(mk(EV_EXPIRED, 1, 0, tt[i], tr[i], ta[i], ts[i], 0));
          tv[i] = 0; tm[i] = 0;
        end else begin
          ta[i] = 0; ts[i] = oseq + 32'd1;
          queue_result(mk(EV_REGEN, 1, 0, tt[i], tr[i], 0, ts[i], 0));
        end
      end
    end
    queue_result(mk(EV_TICK_DONE, 0, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic predict(input lsta_in_t it);
    int hit, freeslot;
    logic mark, any;
    hit = -1; freeslot = -1; mark = 0; any = 0;
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (hit < 0 && tv[i] && tt[i] == it.record_type && tr[i] == it.router_id) hit = i;
    case (it.kind)
      KIND_INSERT: begin
        if (hit >= 0) begin
          ta[hit] = it.record_age; ts[hit] = it.sequence_req;
          queue_result(mk(EV_INSERT_ACK, 1, 0, it.record_type, it.router_id,
                          it.record_age, it.sequence_req, 1));
        end else begin
          for (int i = TABLE_SLOTS - 1; i >= 0; i--) if (!tv[i]) freeslot = i;
          if (freeslot < 0)
            queue_result(mk(EV_INSERT_ACK, 0, 1, it.record_type, it.router_id,
                            it.record_age, it.sequence_req, 1));
          else begin
            for (int j = 0; j < TABLE_SLOTS; j++)
              if (tv[j] && tr[j] == it.router_id) mark = tm[j];
            tv[freeslot] = 1; tt[freeslot] = it.record_type; tr[freeslot] = it.router_id;
            ta[freeslot] = it.record_age; ts[freeslot] = it.sequence_req; tm[freeslot] = mark;
            queue_result(mk(EV_INSERT_ACK, 0, 0, it.record_type, it.router_id,
                            it.record_age, it.sequence_req, 1));
          end
        end
      end
      KIND_DELETE, KIND_LOOKUP: begin
        if (hit < 0)
          queue_result(mk(it.kind, 0, 0, it.record_type, it.router_id, 0, 0, 1));
        else begin
          queue_result(mk(it.kind, 1, 0, it.record_type, it.router_id,
                          ta[hit], ts[hit], 1));
          if (it.kind == KIND_DELETE) begin tv[hit] = 0; tm[hit] = 0; end
        end
      end
      KIND_TICK: age_walk(it.neighbors_busy);
      KIND_REACH: begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tv[i] && tr[i] == it.router_id) begin tm[i] = it.reachable; any = 1; end
        queue_result(mk(EV_REACH_ACK, any, 0, it.record_type, it.router_id, 0, 0, 1));
      end
      default: ;
    endcase
  endtask

  task automatic compare(input lsta_out_t got);
    lsta_out_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: %p", got);
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (got.event_res !== e.event_res) begin
      $error("event_res exp %0d got %0d", e.event_res, got.event_res); fail_count++; end
    if (got.found !== e.found) begin
      $error("found exp %0d got %0d", e.found, got.found); fail_count++; end
    if (got.table_full !== e.table_full) begin
      $error("table_full exp %0d got %0d", e.table_full, got.table_full); fail_count++; end
    if (got.out_type !== e.out_type) begin
      $error("out_type exp %0d got %0d", e.out_type, got.out_type); fail_count++; end
    if (got.out_router !== e.out_router) begin
      $error("out_router exp %h got %h", e.out_router, got.out_router); fail_count++; end
    if (got.out_age !== e.out_age) begin
      $error("out_age exp %0d got %0d", e.out_age, got.out_age); fail_count++; end
    if (got.out_sequence !== e.out_sequence) begin
      $error("out_sequence exp %h got %h", e.out_sequence, got.out_sequence); fail_count++; end
    if (got.last !== e.last) begin
      $error("last exp %0d got %0d", e.last, got.last); fail_count++; end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id = 0; age_limit = 16'd3600; refresh_limit = 16'd1800;
      seq_limit = 32'h7fffffff;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tv[i] = 0; tm[i] = 0; tt[i] = 0; tr[i] = 0; ta[i] = 0; ts[i] = 0;
      end
      fail_count = 0;
    end else begin
      if (result_valid_o) compare(result_o);
      if (start && !busy) predict(item_i);
      if (cfg_we_i)
        case (cfg_idx_i)
          CFG_OWN_ID:  own_id = cfg_data_i;
          CFG_MAX_AGE: age_limit = cfg_data_i[15:0];
          CFG_REFRESH: refresh_limit = cfg_data_i[15:0];
          CFG_MAX_SEQ: seq_limit = cfg_data_i;
          default: ;
        endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Testbench top: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import lsta_pkg::*;

  logic        clk_i, rst_ni, start, busy;
  lsta_in_t    item_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        result_valid_o;
  lsta_out_t   result_o;
  int          fail_count, pending;
  int          idle_pct;          // sender gap percentage for the current phase
  int          quiet_cycles = 0;  // watchdog: cycles with no transaction
  logic [31:0] own_id_now;
  logic [31:0] router_pool [6];

  link_state_table_aging dut (.*);

  lsta_checker chk (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a tick with a full table ends well inside the quiet limit; allow far more.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("** link_state_table_aging: FAILED **");
      $finish;
    end
  end

  // One item transaction: optional random gap, raise start for the accepting edge,
  // then wait until the block is idle again.
  task automatic send(input lsta_in_t it);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    item_i <= it;
    start  <= 1;
    @(posedge clk_i);
    start <= 0;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_OWN_ID) own_id_now = val;
    @(posedge clk_i);
  endtask

  // Block is idle only when all results drained plus its busy window has passed.
  task automatic drain();
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic lsta_in_t mk_item(logic [2:0] k, logic ty, logic [31:0] r,
                                       logic [15:0] a, logic [31:0] s, logic rc,
                                       logic nb);
    lsta_in_t it;
    it.kind = k; it.record_type = ty; it.router_id = r; it.record_age = a;
    it.sequence_req = s; it.reachable = rc; it.neighbors_busy = nb;
    return it;
  endfunction

  // Random item biased toward a small router pool so records collide and age.
  task automatic random_item();
    lsta_in_t    it;
    logic [95:0] rnd;
    int          sel;
    rnd = {$urandom, $urandom, $urandom};
    it = rnd[$bits(lsta_in_t)-1:0];
    sel = $urandom_range(99);
    if (sel < 85) it.router_id = router_pool[$urandom_range(5)];
    if (sel < 3) it.kind = 3'(5 + $urandom_range(2));       // ignored kinds
    else if (sel < 30) it.kind = KIND_INSERT;
    else if (sel < 40) it.kind = KIND_DELETE;
    else if (sel < 50) it.kind = KIND_LOOKUP;
    else if (sel < 85) it.kind = KIND_TICK;
    else it.kind = KIND_REACH;
    if ($urandom_range(3) != 0) it.record_age = 16'($urandom_range(12));
    send(it);
  endtask

  task automatic directed_items();
    send(mk_item(KIND_LOOKUP, 0, 32'h0, 0, 0, 0, 0));                 // miss
    send(mk_item(KIND_DELETE, 1, 32'hffffffff, 0, 0, 0, 0));          // miss
    send(mk_item(KIND_REACH, 1, 32'h5, 0, 0, 1, 0));                  // no record
    for (int i = 0; i < TABLE_SLOTS; i++)
      send(mk_item(KIND_INSERT, i[0], (i < 2) ? own_id_now : router_pool[i % 6] + i,
                   (i == 0) ? 16'hffff : i[15:0],
                   (i == 1) ? 32'h7fffffff : 32'h80000000 + i, 0, 0));
    send(mk_item(KIND_INSERT, 1, 32'hdead0000, 5, 1, 0, 0));          // table full
    send(mk_item(KIND_INSERT, 0, own_id_now, 3, 32'hffffffff, 0, 0)); // replace
    send(mk_item(KIND_REACH, 0, own_id_now, 0, 0, 1, 0));
    send(mk_item(KIND_TICK, 0, 0, 0, 0, 0, 1));                       // busy neighbors
    send(mk_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send(mk_item(3'd7, 1, 32'h1, 1, 1, 1, 1));                        // ignored kind
  endtask

  initial begin
    rst_ni = 0; start = 0; item_i = '0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    idle_pct = 21; own_id_now = 0;
    router_pool = '{32'h0, 32'h1, 32'hffffffff, 32'h80000000, 32'h0a0b0c0d, 32'h7};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Tight limits so aging, refresh, regeneration and expiry all show up.
    cfg_write(CFG_OWN_ID, 32'h0);
    cfg_write(CFG_MAX_AGE, 32'd6);
    cfg_write(CFG_REFRESH, 32'd3);
    cfg_write(CFG_MAX_SEQ, 32'h7fffffff);
    directed_items();
    drain();

    // Phase loop: sender-idle pattern and settings change between phases.
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 21 : (ph < 4) ? 81 : 0;
      case (ph)
        0: begin cfg_write(CFG_MAX_AGE, 2); cfg_write(CFG_REFRESH, 2);
                 cfg_write(CFG_MAX_SEQ, 32'h80000000); end
        1: begin cfg_write(CFG_OWN_ID, 32'hffffffff); cfg_write(CFG_MAX_AGE, 8);
                 cfg_write(CFG_REFRESH, 4); end
        2: begin cfg_write(CFG_MAX_AGE, 65535); cfg_write(CFG_REFRESH, 65535); end
        3: begin cfg_write(CFG_OWN_ID, 32'h1); cfg_write(CFG_MAX_AGE, 5);
                 cfg_write(CFG_REFRESH, 2); cfg_write(CFG_MAX_SEQ, $urandom); end
        4: begin cfg_write(CFG_OWN_ID, $urandom); cfg_write(CFG_MAX_AGE, 4);
                 cfg_write(CFG_REFRESH, 6); end
        default: begin cfg_write(CFG_OWN_ID, 32'h7); cfg_write(CFG_MAX_AGE, 7);
                       cfg_write(CFG_REFRESH, 3); cfg_write(CFG_MAX_SEQ, 32'h7fffffff); end
      endcase
      router_pool[5] = own_id_now;
      repeat (31) random_item();
    end

    drain();
    if (fail_count == 0) $display("** link_state_table_aging: PASSED **");
    else $display("** link_state_table_aging: FAILED **");
    $finish;
  end
endmodule
